// File: hdl/lcdns_pkg.sv
// Shared types, constants and a helper function for the character LCD nibble sequencer.
// Used by the front, the command queue, the back and the top level. No dependencies.
package lcdns_pkg;

   // Expander port bit positions and display geometry.
   localparam int EN_BIT        = 2;
   localparam int RS_BIT        = 0;
   localparam int BACKLIGHT_BIT = 3;
   localparam int DISPLAY_ROWS  = 4;

   localparam logic [7:0] EN_MASK = 8'(1 << EN_BIT);
   localparam logic [7:0] RS_MASK = 8'(1 << RS_BIT);
   localparam logic [7:0] BL_MASK = 8'(1 << BACKLIGHT_BIT);
   localparam logic [7:0] ROW_CLAMP = 8'(DISPLAY_ROWS - 1);

   // Stream payload widths.
   localparam int REQ_W = 32;
   localparam int RSP_W = 16;

   // Operation codes.
   localparam logic [3:0] FUNC_INIT     = 4'd0;
   localparam logic [3:0] FUNC_CHAR     = 4'd1;
   localparam logic [3:0] FUNC_LIGHT    = 4'd2;
   localparam logic [3:0] FUNC_CLEAR    = 4'd3;
   localparam logic [3:0] FUNC_HOME     = 4'd4;
   localparam logic [3:0] FUNC_BLINK    = 4'd5;
   localparam logic [3:0] FUNC_CURSOR   = 4'd6;
   localparam logic [3:0] FUNC_DISPLAY  = 4'd7;
   localparam logic [3:0] FUNC_SHIFT    = 4'd8;
   localparam logic [3:0] FUNC_POSITION = 4'd9;

   // Controller instructions.
   localparam logic [7:0] INSTR_CLEAR   = 8'h01;
   localparam logic [7:0] INSTR_HOME    = 8'h02;
   localparam logic [7:0] INSTR_ENTRY   = 8'h04;
   localparam logic [7:0] INSTR_DISPLAY = 8'h08;
   localparam logic [7:0] INSTR_DDRAM   = 8'h80;
   localparam logic [7:0] ROW1_OFFSET   = 8'h40;

   // Display flag bit positions.
   localparam int FLAG_BLINK   = 0;
   localparam int FLAG_CURSOR  = 1;
   localparam int FLAG_DISPLAY = 2;
   localparam logic [2:0] FLAGS_RESET     = 3'b111;
   localparam logic [2:0] FLAGS_AFTER_INIT = 3'b110;

   // Waits in milliseconds.
   localparam logic [5:0] WAIT_POWER      = 6'd50;
   localparam logic [5:0] WAIT_NONE       = 6'd0;
   localparam logic [5:0] WAIT_STROBE     = 6'd1;
   localparam logic [5:0] WAIT_INIT_LONG  = 6'd5;
   localparam logic [5:0] WAIT_INIT_SHORT = 6'd1;

   // Last nibble index of the init sequence, with and without function set.
   localparam logic [3:0] INIT_LAST_TWO = 4'd13;
   localparam logic [3:0] INIT_LAST_ONE = 4'd11;
   localparam logic [3:0] INSTR_LAST    = 4'd1;

   // Configuration register indexes.
   localparam logic [1:0] REG_ROWS   = 2'd0;
   localparam logic [1:0] REG_LINE   = 2'd1;
   localparam logic [1:0] REG_DEVICE = 2'd2;

   // Command queue.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      KIND_INIT  = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_LIGHT = 2'd2,
      KIND_INSTR = 2'd3
   } lcdns_kind_type;

   typedef struct packed {
      lcdns_kind_type kind;
      logic           two_row;
      logic [7:0]     data;
      logic           enable;
      logic           text_done;
   } lcdns_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } lcdns_fifo_stat_type;

   // Nibbles of the init sequence. With one line the function set pair is skipped.
   function automatic logic [3:0] init_nibble(input logic [3:0] idx, input logic two_row);
      logic [3:0] eff;
      logic [3:0] nib;
      eff = (!two_row && idx >= 4'd4) ? idx + 4'd2 : idx;
      unique case (eff)
         4'd0, 4'd1, 4'd2: nib = 4'h3;
         4'd3, 4'd4:       nib = 4'h2;
         4'd5:             nib = 4'h8;
         4'd7, 4'd9:       nib = 4'hF;
         4'd11:            nib = 4'hE;
         4'd13:            nib = 4'h1;
         default:          nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

// File: hdl/lcdns_front.sv
// Front end: accepts request items, resolves flags and cursor address, and queues commands.
// Depends on lcdns_pkg.
module lcdns_front import lcdns_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [3:0] func, [11:4] char_code, [12] enable, [20:13] column, [28:21] row, rest zero
   input  logic [REQ_W-1:0]    req_tdata,
   input  logic                req_tlast,
   input  logic [2:0]          rows_in_use,
   input  logic [5:0]          line_length,
   input  lcdns_fifo_stat_type fifo_stat,
   output logic                push,
   output lcdns_cmd_type       push_cmd
);

   logic [2:0] flags_ff, flags_in;
   logic       entry_ff, entry_in;

   logic [3:0] func;
   logic [7:0] char_code;
   logic       enable;
   logic [7:0] column;
   logic [7:0] row;
   logic       accept;
   logic       known;
   logic [1:0] row_clamped;
   logic [2:0] row_limit;
   logic [1:0] row_sel;
   logic [7:0] offset;
   logic [2:0] flag_bit;

   assign func      = req_tdata[3:0];
   assign char_code = req_tdata[11:4];
   assign enable    = req_tdata[12];
   assign column    = req_tdata[20:13];
   assign row       = req_tdata[28:21];

   assign req_tready = !fifo_stat.full;
   assign accept     = req_tvalid && req_tready;

   // Row is clamped to the last physical line, then to the configured line count.
   always_comb begin
      row_clamped = (row > ROW_CLAMP) ? ROW_CLAMP[1:0] : row[1:0];
      row_limit   = (rows_in_use == 3'd0) ? 3'd0 : rows_in_use - 3'd1;
      row_sel     = ({1'b0, row_clamped} > row_limit) ? row_limit[1:0] : row_clamped;
      unique case (row_sel)
         2'd0:    offset = 8'h00;
         2'd1:    offset = ROW1_OFFSET;
         2'd2:    offset = {2'b00, line_length};
         default: offset = ROW1_OFFSET + {2'b00, line_length};
      endcase
   end

   always_comb begin
      flags_in           = flags_ff;
      entry_in           = entry_ff;
      known              = 1'b1;
      flag_bit           = 3'b000;
      push_cmd.kind      = KIND_INSTR;
      push_cmd.two_row   = rows_in_use > 3'd1;
      push_cmd.data      = 8'h00;
      push_cmd.enable    = enable;
      push_cmd.text_done = 1'b0;
      unique case (func)
         FUNC_INIT: begin
            push_cmd.kind = KIND_INIT;
            flags_in      = FLAGS_AFTER_INIT;
            entry_in      = 1'b1;
         end
         FUNC_CHAR: begin
            push_cmd.kind      = KIND_CHAR;
            push_cmd.data      = char_code;
            push_cmd.text_done = req_tlast;
         end
         FUNC_LIGHT:    push_cmd.kind = KIND_LIGHT;
         FUNC_CLEAR:    push_cmd.data = INSTR_CLEAR;
         FUNC_HOME:     push_cmd.data = INSTR_HOME;
         FUNC_BLINK, FUNC_CURSOR, FUNC_DISPLAY: begin
            unique case (func)
               FUNC_BLINK:  flag_bit = 3'(1 << FLAG_BLINK);
               FUNC_CURSOR: flag_bit = 3'(1 << FLAG_CURSOR);
               default:     flag_bit = 3'(1 << FLAG_DISPLAY);
            endcase
            flags_in      = enable ? (flags_ff | flag_bit) : (flags_ff & ~flag_bit);
            push_cmd.data = INSTR_DISPLAY | {5'b00000, flags_in};
         end
         FUNC_SHIFT: begin
            entry_in      = enable;
            push_cmd.data = INSTR_ENTRY | {7'b0000000, enable};
         end
         FUNC_POSITION: push_cmd.data = INSTR_DDRAM | (column + offset);
         default:       known = 1'b0;
      endcase
   end

   // Unused operation codes are taken and dropped without a trace.
   assign push = accept && known;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FLAGS_RESET;
         entry_ff <= 1'b1;
      end else if (push) begin
         flags_ff <= flags_in;
         entry_ff <= entry_in;
      end
   end

endmodule

// File: hdl/lcdns_fifo.sv
// Short command queue between the front and the back of the sequencer.
// Depends on lcdns_pkg for the command type and the depth.
module lcdns_fifo import lcdns_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lcdns_cmd_type       push_cmd,
   input  logic                pop,
   output lcdns_cmd_type       head,
   output lcdns_fifo_stat_type stat
);

   lcdns_cmd_type      entries_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;

   assign head       = entries_ff[rd_ptr_ff];
   assign stat.empty = count_ff == '0;
   assign stat.full  = count_ff == (FIFO_AW + 1)'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: hdl/lcdns_back.sv
// Back end: walks each queued command through its expander bytes and keeps the port shadow.
// Depends on lcdns_pkg. Drives the registered result channel.
module lcdns_back import lcdns_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  lcdns_cmd_type       head,
   input  lcdns_fifo_stat_type fifo_stat,
   output logic                pop,
   output logic                idle,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PRE  = 4'b0010,
      ST_NIB  = 4'b0100,
      ST_POST = 4'b1000
   } lcdns_state_type;

   lcdns_state_type state_ff, state_in;
   lcdns_cmd_type   cur_ff, cur_in;
   logic [3:0]      idx_ff, idx_in;
   logic [1:0]      phase_ff, phase_in;
   logic            pre_ff, pre_in;
   logic [7:0]      shadow_ff, shadow_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff;
   logic [5:0]      rsp_wait_ff;
   logic            rsp_last_ff;
   logic            rsp_done_ff;

   logic            out_free;
   logic            emit;
   logic            finish;
   logic [7:0]      byte_v;
   logic [5:0]      wait_v;
   logic [3:0]      nib_val;
   logic [3:0]      nib_last;
   logic [5:0]      extra;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign idle     = state_ff == ST_IDLE;

   always_comb begin
      if (cur_ff.kind == KIND_INIT) begin
         nib_val  = init_nibble(idx_ff, cur_ff.two_row);
         nib_last = cur_ff.two_row ? INIT_LAST_TWO : INIT_LAST_ONE;
      end else begin
         nib_val  = idx_ff[0] ? cur_ff.data[3:0] : cur_ff.data[7:4];
         nib_last = INSTR_LAST;
      end
      // Init nibbles 0 and 1 get the long wait on their last byte, nibble 2 the short one.
      if (cur_ff.kind == KIND_INIT && idx_ff <= 4'd1) begin
         extra = WAIT_INIT_LONG;
      end else if (cur_ff.kind == KIND_INIT && idx_ff == 4'd2) begin
         extra = WAIT_INIT_SHORT;
      end else begin
         extra = WAIT_NONE;
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      pre_in   = pre_ff;
      emit     = 1'b0;
      finish   = 1'b0;
      byte_v   = shadow_ff;
      wait_v   = WAIT_NONE;
      pop      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_PRE: begin
            if (out_free) begin
               unique case (cur_ff.kind)
                  KIND_INIT: begin
                     emit = 1'b1;
                     if (!pre_ff) begin
                        byte_v = 8'h00;
                        wait_v = WAIT_POWER;
                        pre_in = 1'b1;
                     end else begin
                        byte_v   = shadow_ff | BL_MASK;
                        state_in = ST_NIB;
                     end
                  end
                  KIND_CHAR: begin
                     emit     = 1'b1;
                     byte_v   = shadow_ff | RS_MASK;
                     state_in = ST_NIB;
                  end
                  KIND_LIGHT: begin
                     emit   = 1'b1;
                     byte_v = cur_ff.enable ? (shadow_ff | BL_MASK) : (shadow_ff & ~BL_MASK);
                     finish = 1'b1;
                  end
                  KIND_INSTR: begin
                     state_in = ST_NIB;
                  end
               endcase
            end
         end
         ST_NIB: begin
            if (out_free) begin
               emit = 1'b1;
               unique case (phase_ff)
                  2'd0: begin
                     byte_v   = {nib_val, shadow_ff[3:0]};
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     byte_v   = shadow_ff | EN_MASK;
                     wait_v   = WAIT_STROBE;
                     phase_in = 2'd2;
                  end
                  default: begin
                     byte_v   = shadow_ff & ~EN_MASK;
                     wait_v   = WAIT_STROBE + extra;
                     phase_in = 2'd0;
                     if (idx_ff == nib_last) begin
                        if (cur_ff.kind == KIND_CHAR) begin
                           state_in = ST_POST;
                        end else begin
                           finish = 1'b1;
                        end
                     end else begin
                        idx_in = idx_ff + 4'd1;
                     end
                  end
               endcase
            end
         end
         ST_POST: begin
            if (out_free) begin
               emit   = 1'b1;
               byte_v = shadow_ff & ~RS_MASK;
               finish = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // The next command is picked up in the cycle its predecessor sends its last byte.
      if ((state_ff == ST_IDLE || finish) && !fifo_stat.empty) begin
         pop      = 1'b1;
         cur_in   = head;
         idx_in   = 4'd0;
         phase_in = 2'd0;
         pre_in   = 1'b0;
         state_in = (head.kind == KIND_INSTR) ? ST_NIB : ST_PRE;
      end else if (finish) begin
         state_in = ST_IDLE;
      end

      shadow_in    = emit ? byte_v : shadow_ff;
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 4'd0;
         phase_ff     <= 2'd0;
         pre_ff       <= 1'b0;
         shadow_ff    <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         pre_ff       <= pre_in;
         shadow_ff    <= shadow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_byte_ff <= byte_v;
         rsp_wait_ff <= wait_v;
         rsp_last_ff <= finish;
         rsp_done_ff <= finish && cur_ff.text_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_wait_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule

// File: hdl/char_lcd_nibble_sequencer_core.sv
// Top level of the character LCD nibble sequencer: configuration registers and wiring.
// Depends on lcdns_pkg, lcdns_front, lcdns_fifo and lcdns_back.
//
// Each request item names one LCD operation; the block answers with the series of
// I/O expander port bytes that perform it on a 4-bit HD44780 interface, each with a
// wait in milliseconds. rsp_tlast marks the final byte of an item, and rsp_tuser marks
// the final byte of a character that came with req_tlast set (end of a string).
// Bytes per item: init 44 (38 with one line), character 8, backlight 1, every other
// command 6; unused operation codes give nothing. The back end sends one byte per
// cycle while rsp_tready allows; if a command waits, a new item starts in the cycle
// after the previous one's last byte. A taken item passes the queue and the back end
// state register to the output register. A four-entry command queue lets the front
// keep taking items while the back works or the receiver stalls; req_tready drops only
// when the queue is full. A stall on rsp_tready holds the output register and freezes
// the byte sequencer. Reset clears the expander shadow, sets all display flags and the
// entry shift flag, and loads the registers with 2 lines, 16 characters per line and
// address 39. Registers sit at bytes 0, 4 and 8; rows and line length are read live.
module char_lcd_nibble_sequencer_core import lcdns_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [3:0] func, [11:4] char_code, [12] enable, [20:13] column, [28:21] row, rest zero
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [7:0] expander_byte, [13:8] wait_ms, rest zero
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   // [0] text_done
   output logic             rsp_tuser,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [2:0] rows_ff;
   logic [5:0] line_ff;
   logic [6:0] device_ff;
   logic       csr_write;

   lcdns_fifo_stat_type fifo_stat;
   lcdns_cmd_type       push_cmd;
   lcdns_cmd_type       head;
   logic                push;
   logic                back_pop;
   logic                back_idle;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= 3'd2;
         line_ff   <= 6'd16;
         device_ff <= 7'd39;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_ROWS:   rows_ff   <= csr_pwdata[2:0];
            REG_LINE:   line_ff   <= csr_pwdata[5:0];
            REG_DEVICE: device_ff <= csr_pwdata[6:0];
            default:    rows_ff   <= rows_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ROWS:   csr_prdata = {29'd0, rows_ff};
         REG_LINE:   csr_prdata = {26'd0, line_ff};
         REG_DEVICE: csr_prdata = {25'd0, device_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   lcdns_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rows_in_use (rows_ff),
      .line_length (line_ff),
      .fifo_stat   (fifo_stat),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   lcdns_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (back_pop),
      .head     (head),
      .stat     (fifo_stat)
   );

   lcdns_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .fifo_stat  (fifo_stat),
      .pop        (back_pop),
      .idle       (back_idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The end-of-string mark only ever rides on the final byte of an item.
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("text_done without last");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_pop |-> !fifo_stat.empty)
      else $error("command popped from an empty queue");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_stat.full)
      else $error("command pushed into a full queue");

   // An idle back end picks up a waiting command right away.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      back_idle && !fifo_stat.empty |=> !back_idle)
      else $error("back end idle with commands queued");

endmodule
